// ===== sv/lal_pkg.sv =====
// ----------------------------------------------------------------------------
// lal_pkg: shared types and constants for the log-average luminance block
// Holds the luminance weights, the epsilon and the item carried between the
// front and back parts.
// ----------------------------------------------------------------------------
package lal_pkg;
	localparam int unsigned DIM_W  = 12;
	localparam int unsigned CNT_W  = 24;
	localparam int unsigned SUM_W  = 48;
	localparam int unsigned CHAN_W = 16;

	localparam logic [15:0] COEF_R  = 16'd13933;
	localparam logic [15:0] COEF_G  = 16'd46871;
	localparam logic [15:0] COEF_B  = 16'd4732;
	localparam logic [31:0] LUM_EPS = 32'd168;

	localparam logic [4:0] POINT_LUM = 5'd24;
	localparam logic [4:0] POINT_OUT = 5'd8;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic              last;
		logic [CNT_W-1:0]  total;
	} pix_t;
endpackage

// ===== sv/lal_fifo.sv =====
// ----------------------------------------------------------------------------
// lal_fifo: small register queue
// A first-in first-out buffer with the oldest entry shown on rdata.
// ----------------------------------------------------------------------------
module lal_fifo #(
	parameter int unsigned W     = 16,
	parameter int unsigned DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]    mem_q [DEPTH];
	logic [AW-1:0]   wptr_q, rptr_q;
	logic [AW:0]     cnt_q;
	logic            do_wr, do_rd;

	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == AW'(DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == AW'(DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end
endmodule

// ===== sv/lal_front.sv =====
// ----------------------------------------------------------------------------
// lal_front: frame counter and configuration registers
// Counts pixels against the frame size and tags the last pixel of a frame.
// ----------------------------------------------------------------------------
module lal_front #(
	parameter int unsigned MAX_DIM = 2048
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic                        cfg_index,
	input  logic [lal_pkg::DIM_W-1:0]   cfg_data,
	input  logic                        accept,
	input  logic [lal_pkg::CHAN_W-1:0]  red,
	input  logic [lal_pkg::CHAN_W-1:0]  green,
	input  logic [lal_pkg::CHAN_W-1:0]  blue,
	output lal_pkg::pix_t               item
);
	import lal_pkg::*;

	logic [DIM_W-1:0] width_q, height_q;
	logic [CNT_W-1:0] seen_q, seen_nxt, total;
	logic [DIM_W-1:0] w_c, h_c;

	function automatic logic [DIM_W-1:0] clamp(input logic [DIM_W-1:0] d);
		if (d == '0) begin
			return DIM_W'(1);
		end else if (CNT_W'(d) > CNT_W'(MAX_DIM)) begin
			return DIM_W'(MAX_DIM);
		end
		return d;
	endfunction

	assign w_c      = clamp(width_q);
	assign h_c      = clamp(height_q);
	assign total    = CNT_W'(w_c) * CNT_W'(h_c);
	assign seen_nxt = seen_q + 1'b1;

	assign item.red   = red;
	assign item.green = green;
	assign item.blue  = blue;
	assign item.last  = (seen_nxt >= total);
	assign item.total = total;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1024);
			height_q <= DIM_W'(1024);
			seen_q   <= '0;
		end else begin
			if (cfg_write && cfg_index == REG_WIDTH) begin
				width_q <= cfg_data;
			end
			if (cfg_write && cfg_index == REG_HEIGHT) begin
				height_q <= cfg_data;
			end
			if (accept) begin
				seen_q <= item.last ? '0 : seen_nxt;
			end
		end
	end
endmodule

// ===== sv/lal_log2.sv =====
// ----------------------------------------------------------------------------
// lal_log2: iterative fixed-point base-2 logarithm
// Normalises the input, then finds one fraction bit per cycle by squaring.
// ----------------------------------------------------------------------------
module lal_log2 #(
	parameter int unsigned LOG_FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [31:0]               x,
	input  logic [4:0]                point,
	output logic                      done,
	output logic [lal_pkg::SUM_W-1:0] result
);
	import lal_pkg::*;

	localparam int unsigned IW = $clog2(LOG_FRAC_BITS + 1);

	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_NORM = 3'b010,
		L_SQR  = 3'b100
	} lstate_t;

	lstate_t                  st_q;
	logic [31:0]              x_q;
	logic [4:0]               point_q;
	logic [4:0]               p_q, p_c;
	logic [30:0]              m_q, m_c;
	logic [LOG_FRAC_BITS-1:0] frac_q;
	logic [IW-1:0]            it_q;
	logic [61:0]              sq;
	logic [31:0]              m2;
	logic signed [6:0]        ipart;
	logic [62:0]              wide;

	always_comb begin
		p_c = '0;
		for (int i = 0; i < 32; i++) begin
			if (x_q[i]) begin
				p_c = 5'(i);
			end
		end
	end

	assign wide  = {x_q, 31'b0} >> ({1'b0, p_c} + 6'd1);
	assign m_c   = wide[30:0];
	assign sq    = {31'b0, m_q} * {31'b0, m_q};
	assign m2    = sq[61:30];
	assign ipart = $signed({2'b0, p_q}) - $signed({2'b0, point_q});
	assign result = (SUM_W'(ipart) << LOG_FRAC_BITS) + SUM_W'(frac_q);
	assign done  = (st_q == L_SQR) && (it_q == IW'(LOG_FRAC_BITS));

	always_ff @(posedge clk) begin
		case (st_q)
			L_IDLE: begin
				x_q     <= x;
				point_q <= point;
			end
			L_NORM: begin
				p_q    <= p_c;
				m_q    <= m_c;
				frac_q <= '0;
			end
			L_SQR: begin
				if (it_q != IW'(LOG_FRAC_BITS)) begin
					m_q    <= m2[31] ? m2[31:1] : m2[30:0];
					frac_q <= {frac_q[LOG_FRAC_BITS-2:0], m2[31]};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= L_IDLE;
			it_q <= '0;
		end else begin
			case (st_q)
				L_IDLE: begin
					if (start) begin
						st_q <= L_NORM;
					end
				end
				L_NORM: begin
					st_q <= L_SQR;
					it_q <= '0;
				end
				L_SQR: begin
					if (it_q == IW'(LOG_FRAC_BITS)) begin
						st_q <= L_IDLE;
					end else begin
						it_q <= it_q + 1'b1;
					end
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/lal_back.sv =====
// ----------------------------------------------------------------------------
// lal_back: luminance, log accumulation and end-of-frame average
// Works one queued pixel at a time; on the last pixel of a frame it divides
// the log sum by the pixel count and searches the matching Q8.8 value.
// ----------------------------------------------------------------------------
module lal_back #(
	parameter int unsigned LOG_FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  lal_pkg::pix_t              q_item,
	output logic                       q_pop,
	input  logic                       res_full,
	output logic                       res_push,
	output logic [lal_pkg::CHAN_W-1:0] res_data
);
	import lal_pkg::*;

	localparam int unsigned DW = SUM_W + 1;
	localparam int unsigned MW = SUM_W + 2;

	typedef enum logic [9:0] {
		B_IDLE   = 10'b0000000001,
		B_MUL    = 10'b0000000010,
		B_SUM    = 10'b0000000100,
		B_LSTART = 10'b0000001000,
		B_LWAIT  = 10'b0000010000,
		B_DINIT  = 10'b0000100000,
		B_DIV    = 10'b0001000000,
		B_ESTART = 10'b0010000000,
		B_EWAIT  = 10'b0100000000,
		B_PUSH   = 10'b1000000000
	} bstate_t;

	bstate_t          st_q;
	pix_t             pix_q;
	logic [31:0]      pr_q, pg_q, pb_q, lum_q;
	logic [SUM_W-1:0] sum_q;
	logic             neg_q;
	logic [DW-1:0]    dvd_q;
	logic [CNT_W:0]   rem_q;
	logic [CNT_W:0]   rem_sh;
	logic [5:0]       dcnt_q;
	logic signed [MW-1:0] mean_q;
	logic [15:0]      y_q, cand;
	logic [3:0]       bit_q;
	logic             log_start, log_done;
	logic [31:0]      log_x;
	logic [4:0]       log_point;
	logic [SUM_W-1:0] log_res;
	logic [SUM_W-1:0] mag;

	lal_log2 #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.x      (log_x),
		.point  (log_point),
		.done   (log_done),
		.result (log_res)
	);

	assign cand      = y_q | (16'd1 << bit_q);
	assign log_start = (st_q == B_LSTART) || (st_q == B_ESTART);
	assign log_x     = (st_q == B_LSTART) ? lum_q : {16'b0, cand};
	assign log_point = (st_q == B_LSTART) ? POINT_LUM : POINT_OUT;
	assign q_pop     = (st_q == B_IDLE) && !q_empty;
	assign res_push  = (st_q == B_PUSH) && !res_full;
	assign res_data  = y_q;
	assign mag       = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign rem_sh    = {rem_q[CNT_W-1:0], dvd_q[DW-1]};

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: pix_q <= q_item;
			B_MUL: begin
				pr_q <= {16'b0, pix_q.red}   * {16'b0, COEF_R};
				pg_q <= {16'b0, pix_q.green} * {16'b0, COEF_G};
				pb_q <= {16'b0, pix_q.blue}  * {16'b0, COEF_B};
			end
			B_SUM: lum_q <= pr_q + pg_q + pb_q + LUM_EPS;
			B_DINIT: begin
				// Floor division of a negative sum: divide |s| + c - 1.
				neg_q  <= sum_q[SUM_W-1];
				dvd_q  <= sum_q[SUM_W-1]
					? DW'(mag) + DW'(pix_q.total) - DW'(1) : DW'(mag);
				rem_q  <= '0;
				dcnt_q <= 6'(DW);
			end
			B_DIV: begin
				if (dcnt_q != '0) begin
					if (rem_sh >= (CNT_W+1)'(pix_q.total)) begin
						rem_q <= rem_sh - (CNT_W+1)'(pix_q.total);
						dvd_q <= {dvd_q[DW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						dvd_q <= {dvd_q[DW-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q - 1'b1;
				end else begin
					mean_q <= neg_q ? -$signed(MW'(dvd_q)) : $signed(MW'(dvd_q));
					y_q    <= '0;
					bit_q  <= 4'd15;
				end
			end
			B_EWAIT: begin
				if (log_done) begin
					if ($signed(MW'($signed(log_res))) <= mean_q) begin
						y_q <= cand;
					end
					bit_q <= bit_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= B_IDLE;
			sum_q <= '0;
		end else begin
			case (st_q)
				B_IDLE:   if (!q_empty) st_q <= B_MUL;
				B_MUL:    st_q <= B_SUM;
				B_SUM:    st_q <= B_LSTART;
				B_LSTART: st_q <= B_LWAIT;
				B_LWAIT: begin
					if (log_done) begin
						sum_q <= sum_q + log_res;
						st_q  <= pix_q.last ? B_DINIT : B_IDLE;
					end
				end
				B_DINIT: begin
					sum_q <= '0;
					st_q  <= B_DIV;
				end
				B_DIV:    if (dcnt_q == '0) st_q <= B_ESTART;
				B_ESTART: st_q <= B_EWAIT;
				B_EWAIT: begin
					if (log_done) begin
						st_q <= (bit_q == '0) ? B_PUSH : B_ESTART;
					end
				end
				B_PUSH:   if (!res_full) st_q <= B_IDLE;
				default:  st_q <= B_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/log_average_luminance.sv =====
// The back part takes each pixel through pop, the luminance multiply and sum,
// the log2 start and the iterative log2; a frame's last pixel adds a
// bit-serial divide and sixteen log2 passes of the output search.
// It takes no new pixel until it is through with the last, as it has one shared
// iterative log2 unit; the four-entry pixel queue absorbs short bursts.
// Reset (arst_n low) clears the sum, counters and queues; sizes return to 1024.
// ----------------------------------------------------------------------------
// log_average_luminance: tone-mapping key from an HDR pixel stream
// Accumulates log2 of Rec.709 luminance per pixel and gives the geometric
// mean of the frame in Q8.8 once per frame.
// ----------------------------------------------------------------------------
module log_average_luminance #(
	parameter int unsigned MAX_DIM       = 2048,
	parameter int unsigned LOG_FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic                        cfg_index,
	input  logic [lal_pkg::DIM_W-1:0]   cfg_data,
	input  logic                        push,
	output logic                        full,
	input  logic [lal_pkg::CHAN_W-1:0]  red,
	input  logic [lal_pkg::CHAN_W-1:0]  green,
	input  logic [lal_pkg::CHAN_W-1:0]  blue,
	output logic                        empty,
	input  logic                        pop,
	output logic [lal_pkg::CHAN_W-1:0]  average_luminance
);
	import lal_pkg::*;

	// The front part tags each pixel with its frame's end and pixel count,
	// the queue decouples it from the slow back part.
	pix_t              f_item, q_item;
	logic              accept, q_empty, q_pop;
	logic              res_full, res_push;
	logic [CHAN_W-1:0] res_data;

	assign accept = push && !full;

	lal_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.item      (f_item)
	);

	lal_fifo #(.W($bits(pix_t)), .DEPTH(4)) u_pix_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept),
		.wdata  (f_item),
		.rd     (q_pop),
		.rdata  (q_item),
		.full   (full),
		.empty  (q_empty)
	);

	lal_back #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_item   (q_item),
		.q_pop    (q_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_data)
	);

	// Finished averages wait here so the back part can move on.
	lal_fifo #(.W(CHAN_W), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res_data),
		.rd     (pop),
		.rdata  (average_luminance),
		.full   (res_full),
		.empty  (empty)
	);
endmodule

// ===== dv/tb_log_average_luminance.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_log_average_luminance: self-checking bench for the log-average luminance
// Streams HDR pixels through frames of many shapes, predicts each frame's
// geometric-mean luminance in Q8.8 and checks every item leaving the block.
// ----------------------------------------------------------------------------

// Keeps its own copy of the frame sizes, the log sum and the pixel count,
// and holds the luminance values still owed by the block, oldest first.
class luminance_scoreboard;
	logic [lal_pkg::DIM_W-1:0] width_reg;
	logic [lal_pkg::DIM_W-1:0] height_reg;
	logic [lal_pkg::SUM_W-1:0] log_sum;
	int unsigned               pixels_seen;
	logic [15:0]               owed_means[$];
	int                        errors;

	function new();
		width_reg   = 12'd1024;
		height_reg  = 12'd1024;
		log_sum     = '0;
		pixels_seen = 0;
		errors      = 0;
	endfunction

	function void set_reg(logic idx, logic [lal_pkg::DIM_W-1:0] value);
		if (idx == lal_pkg::REG_WIDTH) begin
			width_reg = value;
		end else begin
			height_reg = value;
		end
	endfunction

	// Log2 of x / 2^point with 16 fraction bits, by leading one and squaring.
	function automatic longint log2_q16(logic [63:0] x, int point);
		int          p;
		logic [63:0] m;
		logic [63:0] frac;
		p    = 63;
		frac = '0;
		while (p > 0 && x[p] == 1'b0)
			p--;
		m = (p > 30) ? (x >> (p - 30)) : (x << (30 - p));
		for (int i = 0; i < 16; i++) begin
			m    = (m * m) >> 30;
			frac = frac << 1;
			if (m >= 64'h8000_0000) begin
				frac = frac | 64'd1;
				m    = m >> 1;
			end
		end
		return longint'(p - point) * 65536 + longint'(frac);
	endfunction

	function automatic int unsigned clamp_dim(logic [lal_pkg::DIM_W-1:0] d);
		if (d == 0)
			return 1;
		if (d > 2048)
			return 2048;
		return d;
	endfunction

	// Mean of the log sum, floored, turned back into the largest Q8.8 value
	// whose log2 does not exceed it.
	function automatic logic [15:0] frame_mean(int unsigned count);
		longint      s;
		longint      mean;
		logic [15:0] y;
		logic [15:0] t;
		s = $signed(log_sum);
		if (s >= 0)
			mean = s / longint'(count);
		else
			mean = -((-s + longint'(count) - 1) / longint'(count));
		y = '0;
		for (int b = 15; b >= 0; b--) begin
			t = y | (16'd1 << b);
			if (log2_q16({48'd0, t}, 8) <= mean)
				y = t;
		end
		return y;
	endfunction

	function void note_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
		logic [63:0] lum;
		int unsigned total;
		longint      l;
		lum = 64'(lal_pkg::COEF_R) * r + 64'(lal_pkg::COEF_G) * g
			+ 64'(lal_pkg::COEF_B) * b + 64'(lal_pkg::LUM_EPS);
		total = clamp_dim(width_reg) * clamp_dim(height_reg);
		l = log2_q16(lum, 24);
		log_sum = log_sum + l[lal_pkg::SUM_W-1:0];
		pixels_seen++;
		if (pixels_seen >= total) begin
			owed_means.push_back(frame_mean(total));
			log_sum     = '0;
			pixels_seen = 0;
		end
	endfunction

	function void check_mean(logic [15:0] actual);
		logic [15:0] want;
		if (owed_means.size() == 0) begin
			$error("average_luminance: unexpected item, actual %0d", actual);
			errors++;
			return;
		end
		want = owed_means.pop_front();
		if (actual !== want) begin
			$error("average_luminance: expected %0d, actual %0d", want, actual);
			errors++;
		end
	endfunction
endclass

module tb_log_average_luminance;
	import lal_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE     = 600;

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic               cfg_index;
	logic [DIM_W-1:0]   cfg_data;
	logic               push;
	logic               full;
	logic [CHAN_W-1:0]  red;
	logic [CHAN_W-1:0]  green;
	logic [CHAN_W-1:0]  blue;
	logic               empty;
	logic               pop;
	logic [CHAN_W-1:0]  average_luminance;

	luminance_scoreboard sb;
	bit                  hold_req;
	bit                  steady;
	int                  idle_cycles;

	log_average_luminance dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full), .red(red), .green(green), .blue(blue),
		.empty(empty), .pop(pop), .average_luminance(average_luminance)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Mostly no pause, some short ones and now and then a long one. While
	// steady is set both sides run flat out.
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// A channel value drawn from one of several bands so that dark, mid,
	// bright and fully random pixels all turn up.
	function automatic logic [15:0] pick_channel();
		case ($urandom_range(0, 4))
			0: begin
				return $urandom_range(0, 15);
			end
			1: begin
				return $urandom_range(0, 255);
			end
			2: begin
				return $urandom_range(16'hFF00, 16'hFFFF);
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	task automatic write_reg(logic idx, logic [DIM_W-1:0] value);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(posedge clk);
		sb.set_reg(idx, value);
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic set_frame(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
	endtask

	// Offers one pixel and holds it until the block takes it.
	task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			push = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push  = 1'b1;
		red   = r;
		green = g;
		blue  = b;
		do
			@(posedge clk);
		while (full);
		sb.note_pixel(r, g, b);
	endtask

	task automatic send_random(int n);
		for (int i = 0; i < n; i++)
			send_pixel(pick_channel(), pick_channel(), pick_channel());
	endtask

	// Lets every owed item drain, then allows for pixels that give no item
	// but may still be in the log2 unit before the sizes change.
	task automatic settle();
		@(negedge clk);
		push = 1'b0;
		while (sb.owed_means.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Receiver: pops with random pauses, and on request stops for a long
	// stretch so that the block backs up and raises full.
	initial begin
		int stall_left;
		stall_left = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pop = 1'b0;
				repeat (4000) @(negedge clk);
				hold_req = 1'b0;
			end
			if (stall_left > 0) begin
				pop = 1'b0;
				stall_left--;
			end else begin
				pop = 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			sb.check_mean(average_luminance);
	end

	// Watchdog on cycles in which no item moves on either side.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_write) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		sb          = new();
		idle_cycles = 0;
		hold_req    = 1'b0;
		steady      = 1'b0;
		arst_n      = 1'b0;
		cfg_write   = 1'b0;
		cfg_index   = REG_WIDTH;
		cfg_data    = '0;
		push        = 1'b0;
		red         = '0;
		green       = '0;
		blue        = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// One-pixel frames (a size of zero counts as one): each pixel's own
		// luminance comes straight back, covering black, full scale, each
		// channel alone and alternating bit patterns.
		set_frame(12'd0, 12'd0);
		send_pixel(16'h0000, 16'h0000, 16'h0000);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'hFFFF, 16'h0000, 16'h0000);
		send_pixel(16'h0000, 16'hFFFF, 16'h0000);
		send_pixel(16'h0000, 16'h0000, 16'hFFFF);
		send_pixel(16'h5555, 16'hAAAA, 16'h5555);
		send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
		send_pixel(16'h0100, 16'h0100, 16'h0100);
		send_pixel(16'h0001, 16'h0000, 16'h0000);
		settle();

		// Two by two frames mixing dark and bright pixels, so that the mean
		// of the logs is negative and the division rounds downwards.
		set_frame(12'd2, 12'd2);
		send_pixel(16'h0000, 16'h0000, 16'h0000);
		send_pixel(16'h0003, 16'h0001, 16'h0007);
		send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_pixel(16'h0000, 16'h0001, 16'h0000);
		send_pixel(16'h0200, 16'h0180, 16'h0040);
		send_pixel(16'h0000, 16'h0000, 16'h0002);
		send_pixel(16'h8000, 16'h0000, 16'h0000);
		send_pixel(16'h0000, 16'h0000, 16'h0001);
		send_random(2);
		settle();

		// Largest width in one line (4095 counts as 2048): the frame is only
		// begun here and stays open into the next section.
		set_frame(12'hFFF, 12'd1);
		send_random(60);
		settle();

		// Tallest frame, still open, then shrunk: the next pixel ends the
		// frame at once because the count already passes the new size.
		set_frame(12'd1, 12'hFFF);
		send_random(7);
		settle();
		set_frame(12'd2, 12'd3);
		send_random(13);
		settle();

		// Random phases of small frames, one with no pauses at all and one
		// with the receiver held off while pixels keep coming.
		for (int phase = 0; phase < 8; phase++) begin
			set_frame(DIM_W'($urandom_range(0, 4)), DIM_W'($urandom_range(0, 4)));
			steady = (phase == 2);
			if (phase == 5)
				hold_req = 1'b1;
			send_random(40);
			steady = 1'b0;
			settle();
		end

		if (sb.errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
